/* design/voxel_coverage_map_defines.svh */
// ----------------------------------------------------------------------------
// voxel coverage map assertion macros
// shared property forms for the concurrent checks of the map
// ----------------------------------------------------------------------------
`ifndef VOXEL_COVERAGE_MAP_DEFINES_SVH
`define VOXEL_COVERAGE_MAP_DEFINES_SVH

// same-cycle implication, checks suspended while in reset
`define VCM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checks suspended while in reset
`define VCM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/vcm_pkg.sv */
// ----------------------------------------------------------------------------
// vcm_pkg
// grid geometry, cell flags, opcodes and helper functions of the voxel map
// ----------------------------------------------------------------------------
package vcm_pkg;

  localparam int GRID_X      = 32;
  localparam int GRID_Y      = 32;
  localparam int GRID_Z      = 32;
  localparam int MAX_RADIUS  = 8;
  localparam int MAX_TARGETS = 64;

  localparam int NCELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int CA_W   = $clog2(NCELLS);

  localparam int POS_W  = 24;
  localparam int RES_W  = 16;
  localparam int RSQ_W  = 15;
  localparam int OFS_W  = 6;
  localparam int CNT_W  = 16;
  localparam int FND_W  = 7;
  localparam int CODE_W = 3;
  localparam int OP_W   = 3;

  localparam int GMAX_XY = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
  localparam int GMAX    = (GMAX_XY > GRID_Z) ? GMAX_XY : GRID_Z;
  // signed cell coordinate: centre plus read offset or sphere offset
  localparam int CRD_W   = $clog2(GMAX + (2 ** (OFS_W - 1))) + 1;

  localparam int RW   = $clog2(MAX_RADIUS + 1) + 1;
  localparam int SQW  = 2 * RW;
  localparam int SUMW = SQW + 2;
  localparam int CMPW = SUMW + RSQ_W;

  localparam logic signed [RW-1:0] R_MAX = RW'(MAX_RADIUS);
  localparam logic signed [RW-1:0] R_MIN = -RW'(MAX_RADIUS);
  localparam logic signed [RW-1:0] R_ONE = RW'(1);

  localparam int TIW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int TCW = $clog2(MAX_TARGETS + 1);

  localparam logic [3:0] F_OBS   = 4'b0001;
  localparam logic [3:0] F_TGT   = 4'b0010;
  localparam logic [3:0] F_SRCH  = 4'b0100;
  localparam logic [3:0] F_FOUND = 4'b1000;

  localparam logic [1:0] AX_X    = 2'd0;
  localparam logic [1:0] AX_Y    = 2'd1;
  localparam logic [1:0] AX_LAST = 2'd2;

  localparam logic REG_RESOLUTION = 1'b0;
  localparam logic REG_SENSOR_RSQ = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_EXPLORE      = 3'd0,
    OP_CHECK        = 3'd1,
    OP_READ         = 3'd2,
    OP_MARK_OBS     = 3'd3,
    OP_ADD_TGT      = 3'd4,
    OP_RESET_SEARCH = 3'd5
  } op_e;

  typedef enum logic [CODE_W-1:0] {
    CC_UNSEEN      = 3'd0,
    CC_FREE        = 3'd1,
    CC_TGT_UNFOUND = 3'd2,
    CC_TGT_FOUND   = 3'd3,
    CC_OBSTACLE    = 3'd4,
    CC_OUTSIDE     = 3'd5
  } cell_code_e;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DIV, S_DWAIT, S_DISP,
    S_EX_RD, S_EX_WR,
    S_CK_TRD, S_CK_CRD, S_CK_WR,
    S_RC_DATA, S_MO_WR, S_AT_WR,
    S_RS_RD, S_RS_WR,
    S_TOT, S_FIN
  } state_e;

  typedef struct packed {
    logic             neg;
    logic [POS_W-1:0] mag;
  } div_res_t;

  function automatic logic in_grid(input logic signed [CRD_W-1:0] x,
                                   input logic signed [CRD_W-1:0] y,
                                   input logic signed [CRD_W-1:0] z);
    return (x >= 0) && (x < GRID_X) && (y >= 0) && (y < GRID_Y) &&
           (z >= 0) && (z < GRID_Z);
  endfunction

  function automatic logic [CA_W-1:0] lin(input logic signed [CRD_W-1:0] x,
                                          input logic signed [CRD_W-1:0] y,
                                          input logic signed [CRD_W-1:0] z);
    return CA_W'(int'(x) + GRID_X * (int'(y) + GRID_Y * int'(z)));
  endfunction

  function automatic logic [SQW-1:0] sq(input logic signed [RW-1:0] v);
    return SQW'(int'(v) * int'(v));
  endfunction

  function automatic logic [CODE_W-1:0] code_of(input logic [3:0] f);
    logic [CODE_W-1:0] c;
    if ((f & F_OBS) != '0)       c = CC_OBSTACLE;
    else if ((f & F_SRCH) == '0) c = CC_UNSEEN;
    else if ((f & F_TGT) != '0)  c = ((f & F_FOUND) != '0) ? CC_TGT_FOUND : CC_TGT_UNFOUND;
    else                         c = CC_FREE;
    return c;
  endfunction

endpackage

/* design/voxel_coverage_map.sv */
// ----------------------------------------------------------------------------
// voxel_coverage_map: 3-d voxel search map with obstacles and targets
// the point is divided by the resolution one axis at a time, then explore walks
//   all 4913 sphere offsets, check visits each listed target, reset_search every cell
// one item at a time; result leaves through an output register
// after reset a clearing pass writes every cell before ready
// ----------------------------------------------------------------------------
`include "voxel_coverage_map_defines.svh"

module voxel_coverage_map
  import vcm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration writes
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [RES_W-1:0]        cfg_wdata_i,
  // input transfer
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [OP_W-1:0]         opcode_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [POS_W-1:0] pos_z_i,
  input  logic signed [OFS_W-1:0] offset_x_i,
  input  logic signed [OFS_W-1:0] offset_y_i,
  input  logic signed [OFS_W-1:0] offset_z_i,
  // result transfer
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [CNT_W-1:0]        new_count_o,
  output logic [CODE_W-1:0]       cell_code_o,
  output logic                    accepted_o,
  output logic [CNT_W-1:0]        searched_total_o,
  output logic [FND_W-1:0]        found_total_o
);

  // sequencer state
  state_e state_q, state_d;

  // configuration registers
  logic [RES_W-1:0] res_q, res_d;
  logic [RSQ_W-1:0] rsq_q, rsq_d;

  // latched item
  logic [OP_W-1:0]         op_q, op_d;
  logic signed [POS_W-1:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic signed [OFS_W-1:0] ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;

  // centre cell, built one axis at a time by the shared divider
  logic [1:0]              ax_q, ax_d;
  logic                    vld_q, vld_d;
  logic signed [CRD_W-1:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;

  // sphere walk offsets
  logic signed [RW-1:0] dx_q, dx_d, dy_q, dy_d, dz_q, dz_d;

  // sweep address, pending cell address, target index and count
  logic [CA_W-1:0] k_q, k_d;
  logic [CA_W-1:0] caddr_q, caddr_d;
  logic [TCW-1:0]  ti_q, ti_d;
  logic [TCW-1:0]  tcnt_q, tcnt_d;

  // working result and running totals
  logic [CNT_W-1:0]  newc_q, newc_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic              acc_q, acc_d;
  logic [CNT_W-1:0]  srch_q, srch_d;
  logic [FND_W-1:0]  fnd_q, fnd_d;

  // output register
  logic              ov_q, ov_d;
  logic [CNT_W-1:0]  o_newc_q, o_newc_d;
  logic [CODE_W-1:0] o_code_q, o_code_d;
  logic              o_acc_q, o_acc_d;
  logic [CNT_W-1:0]  o_srch_q, o_srch_d;
  logic [FND_W-1:0]  o_fnd_q, o_fnd_d;

  // memory ports
  logic            cram_we;
  logic [CA_W-1:0] cram_waddr, cram_raddr;
  logic [3:0]      cram_wdata, cram_rdata;
  logic            tram_we;
  logic [CA_W-1:0] tram_rdata;

  // divider
  logic                    div_start, div_done;
  logic signed [POS_W-1:0] div_num;
  div_res_t                div_q;
  logic [POS_W-1:0]        glim;
  logic                    ax_ok;
  logic signed [CRD_W-1:0] ax_crd;

  // address arithmetic
  logic signed [CRD_W-1:0] gx, gy, gz, rx, ry, rz;
  logic [SUMW-1:0]         d2;
  logic                    in_sph, last_off;
  logic signed [RW-1:0]    ndx, ndy, ndz;
  logic [CNT_W:0]          srch_sum;
  logic [CNT_W:0]          fnd_sum;

  logic in_xfer;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // ---- memories ----
  // cell flags: obstacle, target, searched, found
  vcm_ram #(.DEPTH(NCELLS), .AW(CA_W), .DW(4)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cram_we),
    .waddr_i (cram_waddr),
    .wdata_i (cram_wdata),
    .raddr_i (cram_raddr),
    .rdata_o (cram_rdata)
  );

  // target list, filled in order, read only below the fill count
  vcm_ram #(.DEPTH(MAX_TARGETS), .AW(TIW), .DW(CA_W)) u_tgt_ram (
    .clk_i   (clk_i),
    .we_i    (tram_we),
    .waddr_i (tcnt_q[TIW-1:0]),
    .wdata_i (caddr_q),
    .raddr_i (ti_q[TIW-1:0]),
    .rdata_o (tram_rdata)
  );

  // ---- shared divider, one axis per pass ----
  always_comb begin
    case (ax_q)
      AX_X:    begin div_num = px_q; glim = POS_W'(GRID_X); end
      AX_Y:    begin div_num = py_q; glim = POS_W'(GRID_Y); end
      default: begin div_num = pz_q; glim = POS_W'(GRID_Z); end
    endcase
  end

  vcm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (res_q),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  // negative quotient of nonzero size lies below the grid
  assign ax_ok  = !(div_q.neg && (div_q.mag != '0)) && (div_q.mag < glim);
  assign ax_crd = signed'({1'b0, div_q.mag[CRD_W-2:0]});

  // ---- sphere walk ----
  assign gx = cx_q + CRD_W'(dx_q);
  assign gy = cy_q + CRD_W'(dy_q);
  assign gz = cz_q + CRD_W'(dz_q);
  assign d2 = SUMW'(sq(dx_q)) + SUMW'(sq(dy_q)) + SUMW'(sq(dz_q));
  // squared distance carries an 8-bit fraction in the radius register
  assign in_sph   = (CMPW'({d2, 8'd0}) <= CMPW'(rsq_q));
  assign last_off = (dx_q == R_MAX) && (dy_q == R_MAX) && (dz_q == R_MAX);
  assign ndx = (dx_q == R_MAX) ? R_MIN : dx_q + R_ONE;
  assign ndy = (dx_q == R_MAX) ? ((dy_q == R_MAX) ? R_MIN : dy_q + R_ONE) : dy_q;
  assign ndz = ((dx_q == R_MAX) && (dy_q == R_MAX)) ? dz_q + R_ONE : dz_q;

  // read_cell target
  assign rx = cx_q + CRD_W'(ox_q);
  assign ry = cy_q + CRD_W'(oy_q);
  assign rz = cz_q + CRD_W'(oz_q);

  // saturating totals
  assign srch_sum = {1'b0, srch_q} + {1'b0, newc_q};
  assign fnd_sum  = (CNT_W+1)'(fnd_q) + {1'b0, newc_q};

  // ---- configuration ----
  always_comb begin
    res_d = res_q;
    rsq_d = rsq_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RESOLUTION: res_d = cfg_wdata_i;
        REG_SENSOR_RSQ: rsq_d = cfg_wdata_i[RSQ_W-1:0];
      endcase
    end
  end

  // ---- sequencer ----
  always_comb begin
    state_d = state_q;
    op_d = op_q;
    px_d = px_q; py_d = py_q; pz_d = pz_q;
    ox_d = ox_q; oy_d = oy_q; oz_d = oz_q;
    ax_d = ax_q; vld_d = vld_q;
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q;
    dx_d = dx_q; dy_d = dy_q; dz_d = dz_q;
    k_d = k_q; caddr_d = caddr_q; ti_d = ti_q; tcnt_d = tcnt_q;
    newc_d = newc_q; code_d = code_q; acc_d = acc_q;
    srch_d = srch_q; fnd_d = fnd_q;
    o_newc_d = o_newc_q; o_code_d = o_code_q; o_acc_d = o_acc_q;
    o_srch_d = o_srch_q; o_fnd_d = o_fnd_q;
    ov_d = ov_q && !out_ready_i;
    cram_we = 1'b0;
    cram_waddr = k_q;
    cram_wdata = '0;
    cram_raddr = k_q;
    tram_we = 1'b0;
    div_start = 1'b0;

    unique case (state_q)
      // clearing pass over the cell memory after reset
      S_INIT: begin
        cram_we = 1'b1;
        k_d = k_q + CA_W'(1);
        if (k_q == CA_W'(NCELLS - 1)) begin
          k_d = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          op_d = opcode_i;
          px_d = pos_x_i; py_d = pos_y_i; pz_d = pos_z_i;
          ox_d = offset_x_i; oy_d = offset_y_i; oz_d = offset_z_i;
          newc_d = '0; code_d = CC_UNSEEN; acc_d = 1'b0;
          ax_d = AX_X;
          // zero resolution leaves every point outside
          vld_d = (res_q != '0);
          state_d = (res_q != '0) ? S_DIV : S_DISP;
        end
      end

      S_DIV: begin
        div_start = 1'b1;
        state_d = S_DWAIT;
      end

      S_DWAIT: begin
        if (div_done) begin
          vld_d = vld_q && ax_ok;
          case (ax_q)
            AX_X:    cx_d = ax_crd;
            AX_Y:    cy_d = ax_crd;
            default: cz_d = ax_crd;
          endcase
          if (ax_q == AX_LAST) begin
            state_d = S_DISP;
          end else begin
            ax_d = ax_q + 2'd1;
            state_d = S_DIV;
          end
        end
      end

      S_DISP: begin
        case (op_q)
          OP_EXPLORE: begin
            acc_d = vld_q;
            dx_d = R_MIN; dy_d = R_MIN; dz_d = R_MIN;
            state_d = vld_q ? S_EX_RD : S_TOT;
          end
          OP_CHECK: begin
            acc_d = 1'b1;
            ti_d = '0;
            state_d = (tcnt_q == '0) ? S_TOT : S_CK_TRD;
          end
          OP_READ: begin
            acc_d = vld_q;
            cram_raddr = lin(rx, ry, rz);
            if (vld_q && in_grid(rx, ry, rz)) begin
              state_d = S_RC_DATA;
            end else begin
              code_d = CC_OUTSIDE;
              state_d = S_TOT;
            end
          end
          OP_MARK_OBS: begin
            acc_d = vld_q;
            cram_raddr = lin(cx_q, cy_q, cz_q);
            caddr_d = lin(cx_q, cy_q, cz_q);
            state_d = vld_q ? S_MO_WR : S_TOT;
          end
          OP_ADD_TGT: begin
            cram_raddr = lin(cx_q, cy_q, cz_q);
            caddr_d = lin(cx_q, cy_q, cz_q);
            state_d = vld_q ? S_AT_WR : S_TOT;
          end
          OP_RESET_SEARCH: begin
            acc_d = 1'b1;
            k_d = '0;
            state_d = S_RS_RD;
          end
          default: state_d = S_TOT;
        endcase
      end

      // offsets outside the sphere or the grid are passed over; hits are read, then written
      S_EX_RD: begin
        cram_raddr = lin(gx, gy, gz);
        caddr_d = lin(gx, gy, gz);
        if (in_sph && in_grid(gx, gy, gz)) begin
          state_d = S_EX_WR;
        end else begin
          dx_d = ndx; dy_d = ndy; dz_d = ndz;
          state_d = last_off ? S_TOT : S_EX_RD;
        end
      end

      S_EX_WR: begin
        cram_waddr = caddr_q;
        cram_wdata = cram_rdata | F_SRCH;
        if ((cram_rdata & F_SRCH) == '0) begin
          cram_we = 1'b1;
          newc_d = newc_q + CNT_W'(1);
        end
        dx_d = ndx; dy_d = ndy; dz_d = ndz;
        state_d = last_off ? S_TOT : S_EX_RD;
      end

      // target list entry is on the read port of the list memory
      S_CK_TRD: state_d = S_CK_CRD;

      S_CK_CRD: begin
        cram_raddr = tram_rdata;
        caddr_d = tram_rdata;
        state_d = S_CK_WR;
      end

      S_CK_WR: begin
        cram_waddr = caddr_q;
        cram_wdata = cram_rdata | F_FOUND;
        if (((cram_rdata & F_TGT) != '0) && ((cram_rdata & F_FOUND) == '0) &&
            ((cram_rdata & F_SRCH) != '0)) begin
          cram_we = 1'b1;
          newc_d = newc_q + CNT_W'(1);
        end
        ti_d = ti_q + TCW'(1);
        state_d = (ti_q + TCW'(1) == tcnt_q) ? S_TOT : S_CK_TRD;
      end

      S_RC_DATA: begin
        code_d = code_of(cram_rdata);
        state_d = S_TOT;
      end

      S_MO_WR: begin
        cram_we = 1'b1;
        cram_waddr = caddr_q;
        cram_wdata = cram_rdata | F_OBS;
        state_d = S_TOT;
      end

      S_AT_WR: begin
        cram_waddr = caddr_q;
        cram_wdata = cram_rdata | F_TGT;
        if (((cram_rdata & (F_OBS | F_TGT)) == '0) && (tcnt_q < TCW'(MAX_TARGETS))) begin
          cram_we = 1'b1;
          tram_we = 1'b1;
          tcnt_d = tcnt_q + TCW'(1);
          acc_d = 1'b1;
        end
        state_d = S_TOT;
      end

      // read-modify-write sweep keeping obstacle and target flags
      S_RS_RD: state_d = S_RS_WR;

      S_RS_WR: begin
        cram_we = 1'b1;
        cram_wdata = cram_rdata & (F_OBS | F_TGT);
        k_d = k_q + CA_W'(1);
        if (k_q == CA_W'(NCELLS - 1)) begin
          k_d = '0;
          state_d = S_TOT;
        end else begin
          state_d = S_RS_RD;
        end
      end

      S_TOT: begin
        case (op_q)
          OP_EXPLORE: begin
            if (vld_q) begin
              srch_d = srch_sum[CNT_W] ? '1 : srch_sum[CNT_W-1:0];
            end
          end
          OP_CHECK: begin
            fnd_d = (fnd_sum > (CNT_W+1)'(127)) ? FND_W'(127) : fnd_sum[FND_W-1:0];
          end
          OP_RESET_SEARCH: begin
            srch_d = '0;
            fnd_d = '0;
          end
          default: ;
        endcase
        state_d = S_FIN;
      end

      // hand over as soon as the output register is free
      S_FIN: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          o_newc_d = newc_q;
          o_code_d = code_q;
          o_acc_d = acc_q;
          o_srch_d = srch_q;
          o_fnd_d = fnd_q;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      res_q <= RES_W'(256);
      rsq_q <= RSQ_W'(4096);
      k_q <= '0;
      tcnt_q <= '0;
      srch_q <= '0;
      fnd_q <= '0;
      ov_q <= 1'b0;
      ax_q <= AX_X;
    end else begin
      state_q <= state_d;
      res_q <= res_d;
      rsq_q <= rsq_d;
      k_q <= k_d;
      tcnt_q <= tcnt_d;
      srch_q <= srch_d;
      fnd_q <= fnd_d;
      ov_q <= ov_d;
      ax_q <= ax_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    px_q <= px_d; py_q <= py_d; pz_q <= pz_d;
    ox_q <= ox_d; oy_q <= oy_d; oz_q <= oz_d;
    vld_q <= vld_d;
    cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d;
    dx_q <= dx_d; dy_q <= dy_d; dz_q <= dz_d;
    caddr_q <= caddr_d;
    ti_q <= ti_d;
    newc_q <= newc_d;
    code_q <= code_d;
    acc_q <= acc_d;
    o_newc_q <= o_newc_d;
    o_code_q <= o_code_d;
    o_acc_q <= o_acc_d;
    o_srch_q <= o_srch_d;
    o_fnd_q <= o_fnd_d;
  end

  assign out_valid_o      = ov_q;
  assign new_count_o      = o_newc_q;
  assign cell_code_o      = o_code_q;
  assign accepted_o       = o_acc_q;
  assign searched_total_o = o_srch_q;
  assign found_total_o    = o_fnd_q;

  // ---- checks ----
  `VCM_ASSERT_NXT(a_busy_after_xfer, in_xfer, !in_ready_o, "ready after accepted transfer")
  `VCM_ASSERT_IMP(a_idle_no_write, state_q == S_IDLE, !cram_we, "cell write while idle")
  `VCM_ASSERT_IMP(a_tgt_bound, 1'b1, tcnt_q <= TCW'(MAX_TARGETS), "target list overfilled")
  `VCM_ASSERT_IMP(a_one_kind, out_valid_o, new_count_o == '0 || cell_code_o == '0,
                  "count and cell code both set")

endmodule

/* design/vcm_ram.sv */
// ----------------------------------------------------------------------------
// vcm_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
module vcm_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/vcm_div.sv */
// ----------------------------------------------------------------------------
// vcm_div
// bit-serial restoring divider, signed point over unsigned resolution
// ----------------------------------------------------------------------------
module vcm_div
  import vcm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [POS_W-1:0] dividend_i,
  input  logic        [RES_W-1:0] divisor_i,
  output logic                    done_o,
  output div_res_t                quot_o
);

  localparam int STW = $clog2(POS_W + 1);

  logic             busy_q, busy_d;
  logic [STW-1:0]   cnt_q, cnt_d;
  logic             neg_q, neg_d;
  logic [POS_W-1:0] num_q, num_d;
  logic [RES_W-1:0] rem_q, rem_d;
  logic [RES_W-1:0] dvs_q, dvs_d;
  logic [RES_W:0]   shifted, trial;

  assign shifted = {rem_q, num_q[POS_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign done_o  = busy_q && (cnt_q == '0);
  assign quot_o  = '{neg: neg_q, mag: num_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    num_d  = num_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = STW'(POS_W);
      neg_d  = dividend_i[POS_W-1];
      num_d  = dividend_i[POS_W-1] ? POS_W'(-dividend_i) : POS_W'(dividend_i);
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - STW'(1);
        if (!trial[RES_W]) begin
          rem_d = trial[RES_W-1:0];
          num_d = {num_q[POS_W-2:0], 1'b1};
        end else begin
          rem_d = shifted[RES_W-1:0];
          num_d = {num_q[POS_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    num_q <= num_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

endmodule

/* tb/voxel_coverage_map_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voxel_coverage_map_checker
// keeps its own copy of the grid and the registers, predicts the result of
// every accepted input transfer and compares each result transfer with it
// ----------------------------------------------------------------------------
module voxel_coverage_map_checker
  import vcm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [RES_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [OP_W-1:0]         opcode_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [POS_W-1:0] pos_z_i,
  input  logic signed [OFS_W-1:0] offset_x_i,
  input  logic signed [OFS_W-1:0] offset_y_i,
  input  logic signed [OFS_W-1:0] offset_z_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [CNT_W-1:0]        new_count_i,
  input  logic [CODE_W-1:0]       cell_code_i,
  input  logic                    accepted_i,
  input  logic [CNT_W-1:0]        searched_total_i,
  input  logic [FND_W-1:0]        found_total_i,
  output int                      fails_o,
  output int                      pending_o
);

  typedef struct packed {
    logic [CNT_W-1:0]  new_count;
    logic [CODE_W-1:0] code;
    logic              acc;
    logic [CNT_W-1:0]  searched;
    logic [FND_W-1:0]  found;
  } map_result_t;

  map_result_t      due_q[$];
  logic [3:0]       grid_flags[NCELLS];
  int               tgt_cells[MAX_TARGETS];
  int               tgt_n, searched_n, found_n;
  logic [RES_W-1:0] res_q;
  logic [RSQ_W-1:0] rsq_q;
  int               fails;

  assign fails_o = fails;

  task automatic report(input string what, input int got, input int want);
    $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    fails++;
  endtask

  function automatic bit on_grid(input int x, input int y, input int z);
    return x >= 0 && x < GRID_X && y >= 0 && y < GRID_Y && z >= 0 && z < GRID_Z;
  endfunction

  function automatic int cell_at(input int x, input int y, input int z);
    return x + GRID_X * (y + GRID_Y * z);
  endfunction

  // truncating division of the world point by the voxel edge
  function automatic int axis_cell(input logic signed [POS_W-1:0] p);
    int pv;
    pv = p;
    return pv / int'(res_q);
  endfunction

  function automatic logic [CODE_W-1:0] flag_code(input logic [3:0] f);
    if (f[0]) return CC_OBSTACLE;
    if (!f[2]) return CC_UNSEEN;
    if (f[1]) return f[3] ? CC_TGT_FOUND : CC_TGT_UNFOUND;
    return CC_FREE;
  endfunction

  task automatic predict_map(output map_result_t r);
    int cx, cy, cz, gx, gy, gz, k, n;
    bit centre_ok;
    r = '0;
    n = 0;
    centre_ok = 0;
    if (res_q != 0) begin
      cx = axis_cell(pos_x_i);
      cy = axis_cell(pos_y_i);
      cz = axis_cell(pos_z_i);
      centre_ok = on_grid(cx, cy, cz);
    end
    case (opcode_i)
      OP_EXPLORE: if (centre_ok) begin
        r.acc = 1;
        for (int dz = -MAX_RADIUS; dz <= MAX_RADIUS; dz++)
          for (int dy = -MAX_RADIUS; dy <= MAX_RADIUS; dy++)
            for (int dx = -MAX_RADIUS; dx <= MAX_RADIUS; dx++) begin
              gx = cx + dx;
              gy = cy + dy;
              gz = cz + dz;
              if (256 * (dx * dx + dy * dy + dz * dz) <= int'(rsq_q) &&
                  on_grid(gx, gy, gz)) begin
                k = cell_at(gx, gy, gz);
                if (!grid_flags[k][2]) begin
                  grid_flags[k][2] = 1'b1;
                  n++;
                end
              end
            end
        searched_n = (searched_n + n > 65535) ? 65535 : searched_n + n;
      end
      OP_CHECK: begin
        r.acc = 1;
        for (int i = 0; i < tgt_n; i++) begin
          k = tgt_cells[i];
          if (grid_flags[k][1] && !grid_flags[k][3] && grid_flags[k][2]) begin
            grid_flags[k][3] = 1'b1;
            n++;
          end
        end
        found_n = (found_n + n > 127) ? 127 : found_n + n;
      end
      OP_READ: begin
        r.code = CC_OUTSIDE;
        if (centre_ok) begin
          r.acc = 1;
          gx = cx + int'(offset_x_i);
          gy = cy + int'(offset_y_i);
          gz = cz + int'(offset_z_i);
          if (on_grid(gx, gy, gz)) r.code = flag_code(grid_flags[cell_at(gx, gy, gz)]);
        end
      end
      OP_MARK_OBS: if (centre_ok) begin
        grid_flags[cell_at(cx, cy, cz)][0] = 1'b1;
        r.acc = 1;
      end
      OP_ADD_TGT: if (centre_ok) begin
        k = cell_at(cx, cy, cz);
        if (!grid_flags[k][0] && !grid_flags[k][1] && tgt_n < MAX_TARGETS) begin
          grid_flags[k][1] = 1'b1;
          tgt_cells[tgt_n] = k;
          tgt_n++;
          r.acc = 1;
        end
      end
      OP_RESET_SEARCH: begin
        for (int i = 0; i < NCELLS; i++) grid_flags[i][3:2] = 2'b00;
        searched_n = 0;
        found_n = 0;
        r.acc = 1;
      end
      default: ;
    endcase
    r.new_count = n;
    r.searched = searched_n;
    r.found = found_n;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    map_result_t want, fresh;
    if (!rst_ni) begin
      for (int i = 0; i < NCELLS; i++) grid_flags[i] = '0;
      tgt_n = 0;
      searched_n = 0;
      found_n = 0;
      res_q = 256;
      rsq_q = 4096;
      due_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_RESOLUTION) res_q = cfg_wdata_i;
        else rsq_q = cfg_wdata_i[RSQ_W-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (due_q.size() == 0) begin
          report("unexpected result, new_count", new_count_i, 0);
        end else begin
          want = due_q.pop_front();
          if (new_count_i != want.new_count) report("new_count", new_count_i, want.new_count);
          if (cell_code_i != want.code) report("cell_code", cell_code_i, want.code);
          if (accepted_i != want.acc) report("accepted", accepted_i, want.acc);
          if (searched_total_i != want.searched)
            report("searched_total", searched_total_i, want.searched);
          if (found_total_i != want.found) report("found_total", found_total_i, want.found);
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_map(fresh);
        due_q.insert(due_q.size(), fresh);
      end
    end
    pending_o = due_q.size();
  end

  initial fails = 0;

endmodule

/* tb/voxel_coverage_map_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voxel_coverage_map_tb
// drives directed and random map operations under several resolutions and
// sensor radii, with random gaps on both sides; the checker judges results
// ----------------------------------------------------------------------------
module voxel_coverage_map_tb;
  import vcm_pkg::*;

  // opcodes the block must ignore
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic                    cfg_idx_i = 1'b0;
  logic [RES_W-1:0]        cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [OP_W-1:0]         opcode_i = '0;
  logic signed [POS_W-1:0] pos_x_i = '0;
  logic signed [POS_W-1:0] pos_y_i = '0;
  logic signed [POS_W-1:0] pos_z_i = '0;
  logic signed [OFS_W-1:0] offset_x_i = '0;
  logic signed [OFS_W-1:0] offset_y_i = '0;
  logic signed [OFS_W-1:0] offset_z_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [CNT_W-1:0]        new_count_o;
  logic [CODE_W-1:0]       cell_code_o;
  logic                    accepted_o;
  logic [CNT_W-1:0]        searched_total_o;
  logic [FND_W-1:0]        found_total_o;

  int  fails, pending;
  bit  calm;            // no gaps on either side while set
  int  edge_len = 256;  // shadow of the resolution register, for placing points

  always #5 clk_i = ~clk_i;

  voxel_coverage_map DUT (.*);

  voxel_coverage_map_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .opcode_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .offset_x_i, .offset_y_i, .offset_z_i,
    .out_valid_i(out_valid_o), .out_ready_i, .new_count_i(new_count_o),
    .cell_code_i(cell_code_o), .accepted_i(accepted_o),
    .searched_total_i(searched_total_o), .found_total_i(found_total_o),
    .fails_o(fails), .pending_o(pending)
  );

  // receiver stalls about a third of the time unless calm
  always @(negedge clk_i) out_ready_i = calm || ($urandom_range(0, 99) >= 33);

  // world coordinate somewhere inside the given cell
  function automatic logic signed [POS_W-1:0] world_of(input int c);
    int frac;
    if (edge_len == 0) return POS_W'($urandom);
    frac = $urandom_range(0, edge_len - 1);
    return POS_W'((c < 0) ? c * edge_len - frac : c * edge_len + frac);
  endfunction

  // one input transfer; valid stays up until accepted, gaps only before it
  task automatic send(input logic [OP_W-1:0] op, input logic signed [POS_W-1:0] px,
                      input logic signed [POS_W-1:0] py, input logic signed [POS_W-1:0] pz,
                      input logic [OFS_W-1:0] ox, input logic [OFS_W-1:0] oy,
                      input logic [OFS_W-1:0] oz);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 99) < 33) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    opcode_i = op;
    pos_x_i = px;
    pos_y_i = py;
    pos_z_i = pz;
    offset_x_i = ox;
    offset_y_i = oy;
    offset_z_i = oz;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic at_cell(input logic [OP_W-1:0] op, input int x, input int y, input int z,
                         input int ox = 0, input int oy = 0, input int oz = 0);
    send(op, world_of(x), world_of(y), world_of(z), OFS_W'(ox), OFS_W'(oy), OFS_W'(oz));
  endtask

  // let the block run dry: every result in, plus slack for the output register
  task automatic drain();
    @(negedge clk_i) in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_reg(input logic idx, input int val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = RES_W'(val);
    @(negedge clk_i) cfg_we_i = 1'b0;
    if (idx == REG_RESOLUTION) edge_len = val;
  endtask

  // random item: mostly in-grid cells, some wide noise across every bit
  task automatic random_item(input bit targets_only = 0);
    logic [OP_W-1:0] op;
    int pick;
    pick = $urandom_range(0, 99);
    if (targets_only) op = OP_ADD_TGT;
    else if (pick < 25) op = OP_EXPLORE;
    else if (pick < 40) op = OP_CHECK;
    else if (pick < 62) op = OP_READ;
    else if (pick < 74) op = OP_MARK_OBS;
    else if (pick < 93) op = OP_ADD_TGT;
    else if (pick < 96) op = OP_RESET_SEARCH;
    else op = ($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B;
    if ($urandom_range(0, 9) == 0)
      send(op, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
           OFS_W'($urandom), OFS_W'($urandom), OFS_W'($urandom));
    else
      at_cell(op, $urandom_range(0, GRID_X - 1), $urandom_range(0, GRID_Y - 1),
              $urandom_range(0, GRID_Z - 1), $signed(OFS_W'($urandom)) % 4,
              $signed(OFS_W'($urandom)) % 4, $signed(OFS_W'($urandom)) % 4);
  endtask

  initial begin
    calm = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed part at reset settings: one cell per 256 world units, radius 4 cells
    at_cell(OP_READ, 0, 0, 0);                 // untouched cell reads unseen
    at_cell(OP_ADD_TGT, 2, 2, 2);
    at_cell(OP_ADD_TGT, 2, 2, 2);              // already a target, refused
    at_cell(OP_MARK_OBS, 5, 5, 5);
    at_cell(OP_ADD_TGT, 5, 5, 5);              // obstacle cell, refused
    at_cell(OP_CHECK, 0, 0, 0);                // target not yet searched
    at_cell(OP_EXPLORE, 0, 0, 0);
    at_cell(OP_CHECK, 0, 0, 0);
    at_cell(OP_READ, 2, 2, 2);                 // target found
    at_cell(OP_READ, 2, 2, 2, 3, 3, 3);        // obstacle via offset
    at_cell(OP_READ, 1, 1, 1);                 // searched free
    at_cell(OP_READ, 0, 0, 0, -32, 31, 0);     // offset leaves the grid
    at_cell(OP_READ, 31, 31, 31, 31, -32, -1); // far corner, offset leaves the grid
    at_cell(OP_READ, -1, 0, 0);                // centre outside
    at_cell(OP_EXPLORE, 0, 32, 0);             // centre outside, no effect
    at_cell(OP_MARK_OBS, 0, 0, -1);
    at_cell(OP_ADD_TGT, 40, 0, 0);
    at_cell(OP_EXPLORE, 31, 31, 31);
    send(OP_READ, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 6'sh1F, 6'sh1F, 6'sh1F);
    send(OP_READ, 24'sh800000, 24'sh800000, 24'sh800000, 6'sh20, 6'sh20, 6'sh20);
    at_cell(OP_SPARE_A, 3, 3, 3);
    at_cell(OP_SPARE_B, 3, 3, 3);
    at_cell(OP_RESET_SEARCH, 0, 0, 0);
    at_cell(OP_READ, 2, 2, 2);                 // target back to unseen
    drain();

    // largest edge and radius: whole 17-cube of offsets tried
    set_reg(REG_RESOLUTION, 65535);
    set_reg(REG_SENSOR_RSQ, 16384);
    at_cell(OP_EXPLORE, 16, 16, 16);
    at_cell(OP_CHECK, 0, 0, 0);
    for (int i = 0; i < 8; i++) random_item();
    drain();

    // zero edge: every centre outside
    set_reg(REG_RESOLUTION, 0);
    set_reg(REG_SENSOR_RSQ, 300);
    for (int i = 0; i < 4; i++) random_item();
    drain();

    // smallest edge, zero radius: explore covers the centre alone
    set_reg(REG_RESOLUTION, 1);
    set_reg(REG_SENSOR_RSQ, 0);
    for (int i = 0; i < 8; i++) random_item();
    drain();

    // fill the target list past its end, then search and collect
    set_reg(REG_RESOLUTION, 128);
    set_reg(REG_SENSOR_RSQ, 2000);
    calm = 1'b1;
    for (int i = 0; i < 66; i++) random_item(1);
    calm = 1'b0;
    for (int i = 0; i < 10; i++) begin
      if (i == 5) begin
        // hold off until the block has answered everything so far
        @(negedge clk_i) in_valid_i = 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      random_item();
    end
    drain();

    // back to reset-like settings for the tail
    set_reg(REG_RESOLUTION, 256);
    set_reg(REG_SENSOR_RSQ, 4096);
    for (int i = 0; i < 6; i++) random_item();
    @(negedge clk_i) in_valid_i = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fails == 0) $display("voxel_coverage_map: match");
    else $display("voxel_coverage_map: mismatch");
    $finish;
  end

  // generous bound: clearing pass, large explores and a search reset per item
  initial begin
    #1s;
    $display("voxel_coverage_map: mismatch");
    $finish;
  end

endmodule
